// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

// File: hdl/b32d_pkg.sv
// ----------------------------------------------------------------------------
// b32d_pkg
// Types and constants shared by the base 32 stream decoder modules.
// ----------------------------------------------------------------------------
package b32d_pkg;

    localparam int LEN_BITS_DEFAULT = 16;
    localparam int GROUP_BITS       = 40;
    localparam int QUEUE_DEPTH      = 4;
    localparam logic [15:0] CAP_RESET = 16'hffff;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_OK       = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    // What a request does after its bytes.
    typedef enum logic [1:0] {
        END_NONE,
        END_FINISH,
        END_INVALID
    } t_end_kind;

    // One request from the front to the back.
    typedef struct packed {
        logic [GROUP_BITS-1:0] group;
        logic [2:0]            nbytes;
        t_end_kind             kind;
    } t_job;

endpackage

// File: hdl/base32_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// base32_stream_decoder_unit
// Streaming base 32 decoder: characters in, decoded bytes and end results out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready   i_ch, i_end_of_input
//  output    out        o_out_valid / i_out_ready o_status, o_out_byte,
//                                                 o_total_len, o_last
//  config    in         psel / penable / pready   paddr, pwrite, pwdata, prdata
//
// One character is taken per cycle while the four-entry request queue has room.
// The back emits at most one result per cycle, and only while the output is free:
// each byte of a group is a step of its own, and a request that ends the string
// takes one more step for its end result.
// Reset is synchronous and clears the group, the byte count and the queue.
// A stalled output holds in its register while the front keeps filling the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module base32_stream_decoder_unit #(
    parameter int LEN_BITS = b32d_pkg::LEN_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_total_len,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]    r_capacity;
    logic           in_accept;
    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    logic           q_full;
    b32d_pkg::t_job front_job;
    b32d_pkg::t_job q_head;

    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? 32'd0 : {16'd0, r_capacity};
    assign o_in_ready = !q_full;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= b32d_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_capacity <= pwdata[15:0];
        end
    end

    b32d_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_ch           (i_ch),
        .i_end_of_input (i_end_of_input),
        .o_push         (q_push),
        .o_job          (front_job)
    );

    b32d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    b32d_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_head      (q_head),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_status    (o_status),
        .o_out_byte  (o_out_byte),
        .o_total_len (o_total_len),
        .o_last      (o_last)
    );

    // A request is only issued while the queue has room for it.
    `ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, q_push && q_full)

    // Data bytes never close a string and carry no length.
    `ASSERT_IMPLY(a_data_fields, i_clk, i_rst_n, o_out_valid && o_status == b32d_pkg::ST_DATA, !o_last && o_total_len == 16'd0)

    // Every end result is marked last and carries no byte.
    `ASSERT_IMPLY(a_end_fields, i_clk, i_rst_n, o_out_valid && o_status != b32d_pkg::ST_DATA, o_last && o_out_byte == 8'd0)

endmodule

// File: hdl/b32d_front.sv
// ----------------------------------------------------------------------------
// b32d_front
// Classifies characters, gathers symbols into a group and issues requests.
// ----------------------------------------------------------------------------
module b32d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_ch,
    input  logic             i_end_of_input,
    output logic             o_push,
    output b32d_pkg::t_job   o_job
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PAD   = 8'h3d;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5a;
    localparam logic [7:0] CH_LOA   = 8'h61;
    localparam logic [7:0] CH_LOZ   = 8'h7a;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [4:0] LETTER_COUNT = 5'd26;

    logic [b32d_pkg::GROUP_BITS-1:0] r_group, n_group;
    logic [2:0]                      r_nsym,  n_nsym;

    logic                            is_ws;
    logic                            is_sym;
    logic [7:0]                      sym_off;
    logic [4:0]                      sym;
    logic [5:0]                      shamt;
    logic [b32d_pkg::GROUP_BITS-1:0] grp_sym;
    logic [2:0]                      pad_bytes;

    always_comb begin
        is_ws = (i_ch == CH_SPACE) || (i_ch == CH_TAB) || (i_ch == CH_CR) || (i_ch == CH_LF);
        is_sym = 1'b1;
        sym_off = 8'd0;
        sym = 5'd0;
        if (i_ch >= CH_UPA && i_ch <= CH_UPZ) begin
            sym_off = i_ch - CH_UPA;
            sym = sym_off[4:0];
        end else if (i_ch >= CH_LOA && i_ch <= CH_LOZ) begin
            sym_off = i_ch - CH_LOA;
            sym = sym_off[4:0];
        end else if (i_ch >= CH_TWO && i_ch <= CH_SEVEN) begin
            sym_off = i_ch - CH_TWO;
            sym = sym_off[4:0] + LETTER_COUNT;
        end else begin
            is_sym = 1'b0;
        end
        // Symbol n sits 35 - 5n bits up from the bottom of the group.
        shamt = 6'd35 - {1'b0, r_nsym, 2'b00} - {3'b000, r_nsym};
        grp_sym = r_group | ({35'd0, sym} << shamt);
    end

    always_comb begin
        case (r_nsym)
            3'd2:    pad_bytes = 3'd1;
            3'd4:    pad_bytes = 3'd2;
            3'd5:    pad_bytes = 3'd3;
            3'd7:    pad_bytes = 3'd4;
            default: pad_bytes = 3'd0;
        endcase
    end

    always_comb begin
        n_group = r_group;
        n_nsym = r_nsym;
        o_push = 1'b0;
        o_job.group = '0;
        o_job.nbytes = 3'd0;
        o_job.kind = b32d_pkg::END_FINISH;
        if (i_accept) begin
            if (i_ch == CH_NUL) begin
                o_push = 1'b1;
                n_group = '0;
                n_nsym = 3'd0;
            end else if (is_ws) begin
                if (i_end_of_input) begin
                    o_push = 1'b1;
                    n_group = '0;
                    n_nsym = 3'd0;
                end
            end else if (is_sym) begin
                if (r_nsym == 3'd7) begin
                    o_push = 1'b1;
                    o_job.group = grp_sym;
                    o_job.nbytes = 3'd5;
                    o_job.kind = i_end_of_input ? b32d_pkg::END_FINISH : b32d_pkg::END_NONE;
                    n_group = '0;
                    n_nsym = 3'd0;
                end else if (i_end_of_input) begin
                    // An unfinished group is dropped when the string ends.
                    o_push = 1'b1;
                    n_group = '0;
                    n_nsym = 3'd0;
                end else begin
                    n_group = grp_sym;
                    n_nsym = r_nsym + 3'd1;
                end
            end else begin
                o_push = 1'b1;
                n_group = '0;
                n_nsym = 3'd0;
                if (i_ch == CH_PAD && pad_bytes != 3'd0) begin
                    o_job.group = r_group;
                    o_job.nbytes = pad_bytes;
                end else begin
                    o_job.kind = b32d_pkg::END_INVALID;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= '0;
            r_nsym <= 3'd0;
        end else begin
            r_group <= n_group;
            r_nsym <= n_nsym;
        end
    end

endmodule

// File: hdl/b32d_queue.sv
// ----------------------------------------------------------------------------
// b32d_queue
// Small request queue between the front and the back.
// ----------------------------------------------------------------------------
module b32d_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b32d_pkg::t_job   i_job,
    input  logic             i_pop,
    output b32d_pkg::t_job   o_head,
    output logic             o_empty,
    output logic             o_full
);

    localparam int DEPTH = b32d_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    b32d_pkg::t_job   r_slots [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_cnt == CNT_W'(0));
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_head  = r_slots[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: hdl/b32d_back.sv
// ----------------------------------------------------------------------------
// b32d_back
// Emits the bytes and end results of queued requests, one step per cycle while the output is free.
// ----------------------------------------------------------------------------
module b32d_back #(
    parameter int LEN_BITS = b32d_pkg::LEN_BITS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_capacity,
    input  b32d_pkg::t_job   i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_out_byte,
    output logic [15:0]      o_total_len,
    output logic             o_last
);

    localparam int CMP_W = (LEN_BITS > 16) ? LEN_BITS : 16;

    logic [LEN_BITS-1:0] r_count, n_count;
    logic                r_dropped, n_dropped;
    logic [2:0]          r_idx, n_idx;
    logic                r_valid, n_valid;
    logic [1:0]          r_status, n_status;
    logic [7:0]          r_byte, n_byte;
    logic [15:0]         r_len, n_len;
    logic                r_last, n_last;

    logic                out_free;
    logic                step;
    logic                has_byte;
    logic [7:0]          cur_byte;
    logic                saturated;
    logic [CMP_W-1:0]    count_ext;
    logic [CMP_W-1:0]    cap_ext;
    logic [15:0]         sat_len;

    assign out_free  = !r_valid || i_ready;
    assign step      = !i_empty && out_free;
    assign has_byte  = (r_idx < i_head.nbytes);
    assign saturated = (r_count == '1);
    assign count_ext = CMP_W'(r_count);
    assign cap_ext   = CMP_W'(i_capacity);
    assign sat_len   = (count_ext > CMP_W'(16'hffff)) ? 16'hffff : count_ext[15:0];

    always_comb begin
        case (r_idx)
            3'd0:    cur_byte = i_head.group[39:32];
            3'd1:    cur_byte = i_head.group[31:24];
            3'd2:    cur_byte = i_head.group[23:16];
            3'd3:    cur_byte = i_head.group[15:8];
            3'd4:    cur_byte = i_head.group[7:0];
            default: cur_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_dropped = r_dropped;
        n_idx = r_idx;
        o_pop = 1'b0;
        n_valid = out_free ? 1'b0 : r_valid;
        n_status = r_status;
        n_byte = r_byte;
        n_len = r_len;
        n_last = r_last;
        if (step) begin
            if (has_byte) begin
                if (saturated) begin
                    n_dropped = 1'b1;
                end else begin
                    n_count = r_count + LEN_BITS'(1);
                    if (count_ext < cap_ext) begin
                        n_valid = 1'b1;
                        n_status = b32d_pkg::ST_DATA;
                        n_byte = cur_byte;
                        n_len = 16'd0;
                        n_last = 1'b0;
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
                // A request that does not end the string retires with its last byte.
                if (r_idx == i_head.nbytes - 3'd1 && i_head.kind == b32d_pkg::END_NONE) begin
                    o_pop = 1'b1;
                    n_idx = 3'd0;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end else begin
                o_pop = 1'b1;
                n_idx = 3'd0;
                if (i_head.kind != b32d_pkg::END_NONE) begin
                    n_valid = 1'b1;
                    n_byte = 8'd0;
                    n_last = 1'b1;
                    n_count = '0;
                    n_dropped = 1'b0;
                    if (i_head.kind == b32d_pkg::END_INVALID) begin
                        n_status = b32d_pkg::ST_INVALID;
                        n_len = 16'd0;
                    end else begin
                        n_status = r_dropped ? b32d_pkg::ST_OVERFLOW : b32d_pkg::ST_OK;
                        n_len = sat_len;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dropped <= 1'b0;
            r_idx <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_dropped <= n_dropped;
            r_idx <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_byte <= n_byte;
        r_len <= n_len;
        r_last <= n_last;
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_byte  = r_byte;
    assign o_total_len = r_len;
    assign o_last      = r_last;

endmodule
